[hw/rtl/power_iteration_eigen_macros.svh]
// Assertion macros shared by the power iteration eigen RTL.
`ifndef POWER_ITERATION_EIGEN_MACROS_SVH
`define POWER_ITERATION_EIGEN_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PIE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PIE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/pie_pkg.sv]
// Types and constants shared by the power iteration eigen RTL.
package pie_pkg;

    localparam int WORD_BITS = 32;
    localparam int MAX_W     = WORD_BITS + 2;
    localparam int Q_W       = 17;
    localparam int DIV_STEPS = 17;

    localparam logic [1:0] MODE_MAT   = 2'd0;
    localparam logic [1:0] MODE_VEC   = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [1:0] ST_CONVERGED = 2'd0;
    localparam logic [1:0] ST_LIMIT     = 2'd1;
    localparam logic [1:0] ST_ZERO      = 2'd2;

    localparam logic KIND_EIG = 1'b0;
    localparam logic KIND_VEC = 1'b1;

    localparam logic [1:0] REG_SIZE = 2'd0;
    localparam logic [1:0] REG_TOL  = 2'd1;
    localparam logic [1:0] REG_MAXI = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_PH0,
        S_PH1,
        S_PH2,
        S_SAT,
        S_MAXP,
        S_CHKZ,
        S_DIVS,
        S_DIVR,
        S_DMAX,
        S_DECIDE,
        S_EMIT_EIG,
        S_EMIT_VEC
    } state_t;

    typedef struct packed {
        logic wr_m;
        logic wr_v;
        logic clr;
        logic mul;
        logic acc;
        logic rot;
        logic sat;
        logic maxp;
        logic sel_d;
        logic div_start;
        logic div_step;
        logic commit;
    } ctl_t;

endpackage

[hw/rtl/pie_ram.sv]
// Generic single-port RAM with registered read.
module pie_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [W-1:0]             wdata,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/pie_cell.sv]
// One row cell: matrix row, vector element, accumulator, divider, max chain link.
module pie_cell #(
    parameter int MAX_ORDER = 8,
    parameter int IDX       = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pie_pkg::ctl_t                       ctl,
    input  logic                                sel,
    input  logic [$clog2(MAX_ORDER+1)-1:0]      n,
    input  logic [$clog2(MAX_ORDER)-1:0]        wr_col,
    input  logic signed [pie_pkg::WORD_BITS-1:0] wr_value,
    input  logic [pie_pkg::WORD_BITS-1:0]       m,
    input  logic signed [pie_pkg::WORD_BITS-1:0] x_in,
    output logic signed [pie_pkg::WORD_BITS-1:0] x_out,
    input  logic [pie_pkg::MAX_W-1:0]           max_in,
    output logic [pie_pkg::MAX_W-1:0]           max_out
);
    import pie_pkg::*;

    localparam int AW    = $clog2(MAX_ORDER);
    localparam int NW    = $clog2(MAX_ORDER + 1);
    localparam int ACC_W = 2 * WORD_BITS - 16 + $clog2(MAX_ORDER) + 1;

    logic                        act;
    logic [AW-1:0]               col_reg, col_next;
    logic [AW-1:0]               ram_addr;
    logic signed [WORD_BITS-1:0] rdata;
    logic signed [WORD_BITS-1:0] x_reg;
    logic signed [2*WORD_BITS-1:0] prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [WORD_BITS-1:0] p_reg;
    logic [WORD_BITS:0]          p_neg;
    logic [WORD_BITS-1:0]        pabs;
    logic [WORD_BITS:0]          rem_reg;
    logic [Q_W-1:0]              q_reg;
    logic                        neg_reg;
    logic signed [WORD_BITS-1:0] xnew;
    logic signed [WORD_BITS+1:0] diff;
    logic [MAX_W-1:0]            dabs;
    logic [MAX_W-1:0]            cand;
    logic [MAX_W-1:0]            max_reg;

    assign act      = (NW'(IDX) < n);
    assign ram_addr = ctl.wr_m ? wr_col : col_reg;
    assign col_next = (NW'(col_reg) + NW'(1) == n) ? '0 : col_reg + AW'(1);

    pie_ram #(.W(WORD_BITS), .DEPTH(MAX_ORDER)) u_row (
        .clk   (clk),
        .we    (ctl.wr_m && sel),
        .addr  (ram_addr),
        .wdata (wr_value),
        .rdata (rdata)
    );

    assign p_neg = -{p_reg[WORD_BITS-1], p_reg};
    assign pabs  = p_reg[WORD_BITS-1] ? p_neg[WORD_BITS-1:0] : p_reg;
    assign xnew  = neg_reg ? -$signed({{(WORD_BITS-Q_W){1'b0}}, q_reg})
                           : $signed({{(WORD_BITS-Q_W){1'b0}}, q_reg});
    assign diff  = (WORD_BITS+2)'(xnew) - (WORD_BITS+2)'(x_reg);
    assign dabs  = diff[WORD_BITS+1] ? MAX_W'(-diff) : MAX_W'(diff);
    assign cand  = ctl.sel_d ? dabs : MAX_W'(pabs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (ctl.clr)
        begin
            col_reg <= AW'(IDX);
        end
        else if (ctl.acc && act)
        begin
            col_reg <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_v && sel)
        begin
            x_reg <= wr_value;
        end
        else if (ctl.rot && act)
        begin
            x_reg <= x_in;
        end
        else if (ctl.commit && act)
        begin
            x_reg <= xnew;
        end

        if (ctl.mul)
        begin
            prod_reg <= rdata * x_reg;
        end

        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (ctl.acc && act)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg >>> 16);
        end

        if (ctl.sat)
        begin
            if (acc_reg > $signed(ACC_W'({1'b0, {(WORD_BITS-1){1'b1}}})))
            begin
                p_reg <= {1'b0, {(WORD_BITS-1){1'b1}}};
            end
            else if (acc_reg < $signed({{(ACC_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}}))
            begin
                p_reg <= {1'b1, {(WORD_BITS-1){1'b0}}};
            end
            else
            begin
                p_reg <= acc_reg[WORD_BITS-1:0];
            end
        end

        if (ctl.div_start)
        begin
            rem_reg <= {1'b0, pabs};
            q_reg   <= '0;
            neg_reg <= p_reg[WORD_BITS-1];
        end
        else if (ctl.div_step)
        begin
            if (rem_reg >= {1'b0, m})
            begin
                rem_reg <= (rem_reg - {1'b0, m}) << 1;
                q_reg   <= {q_reg[Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_reg << 1;
                q_reg   <= {q_reg[Q_W-2:0], 1'b0};
            end
        end

        if (ctl.maxp)
        begin
            max_reg <= (act && cand > max_in) ? cand : max_in;
        end
    end

    assign x_out   = x_reg;
    assign max_out = max_reg;

endmodule

[hw/rtl/power_iteration_eigen.sv]
// Power method eigen solver top: config, sequencer, row cell chain, output register.
// Load items (matrix or vector element) are accepted only while idle. A start
// runs iterations: for each matrix column, every row cell reads its row RAM,
// multiplies, and accumulates while the vector rotates one cell along the
// ring; then a max pass down the cell chain, a 17-step divider in each cell,
// and a second chain pass for the largest change. The run then emits n + 1
// results, one per cycle when the output is not stalled; no request is taken
// until the last result is loaded into the output register.
module power_iteration_eigen #(
    parameter int MAX_ORDER = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  mode,
    input  logic [2:0]  row,
    input  logic [2:0]  col,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [2:0]  index,
    output logic signed [31:0] result_value,
    output logic [1:0]  status,
    output logic        last
);
    import pie_pkg::*;

    `include "power_iteration_eigen_macros.svh"

    localparam int AW     = $clog2(MAX_ORDER);
    localparam int NW     = $clog2(MAX_ORDER + 1);
    localparam int PASS_W = $clog2((MAX_ORDER > DIV_STEPS ? MAX_ORDER : DIV_STEPS) + 1);

    state_t            state_reg, state_next;
    ctl_t              ctl;
    logic [3:0]        size_reg;
    logic [15:0]       tol_reg;
    logic [15:0]       maxi_reg;
    logic [NW-1:0]     n_reg, n_next, n_calc;
    logic [NW-1:0]     j_reg, j_next;
    logic [PASS_W-1:0] pass_reg, pass_next;
    logic [15:0]       iter_reg, iter_next;
    logic [WORD_BITS-1:0] m_reg, m_next;
    logic [WORD_BITS-1:0] eig_reg, eig_next;
    logic [1:0]        stat_reg, stat_next;
    logic              in_acc;
    logic              out_load;
    logic              ov_reg;
    logic              kind_reg, kind_next;
    logic [2:0]        idx_reg, idx_next;
    logic [WORD_BITS-1:0] val_reg, val_next;
    logic              last_reg, last_next;
    logic [1:0]        ostat_reg;
    logic [MAX_W-1:0]  chain_max;

    logic signed [WORD_BITS-1:0] x_out [MAX_ORDER];
    logic [MAX_W-1:0]            mx_out [MAX_ORDER];

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign chain_max = mx_out[MAX_ORDER-1];

    always_comb
    begin
        if (size_reg == 4'd0)
        begin
            n_calc = NW'(1);
        end
        else if (int'(size_reg) > MAX_ORDER)
        begin
            n_calc = NW'(MAX_ORDER);
        end
        else
        begin
            n_calc = NW'(size_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 4'd3;
            tol_reg  <= 16'd7;
            maxi_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE: size_reg <= cfg_data[3:0];
                REG_TOL:  tol_reg  <= cfg_data;
                REG_MAXI: maxi_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ORDER; gi++)
        begin : g_cell
            logic signed [WORD_BITS-1:0] ring_in;
            logic [MAX_W-1:0]            chain_in;
            if (gi == MAX_ORDER - 1)
            begin : g_wrap
                assign ring_in = x_out[0];
            end
            else
            begin : g_link
                assign ring_in = (NW'(gi + 1) == n_reg) ? x_out[0] : x_out[gi+1];
            end
            if (gi == 0)
            begin : g_head
                assign chain_in = '0;
            end
            else
            begin : g_body
                assign chain_in = mx_out[gi-1];
            end
            pie_cell #(.MAX_ORDER(MAX_ORDER), .IDX(gi)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .sel      (int'(row) == gi),
                .n        (n_reg),
                .wr_col   (AW'(col)),
                .wr_value (value),
                .m        (m_reg),
                .x_in     (ring_in),
                .x_out    (x_out[gi]),
                .max_in   (chain_in),
                .max_out  (mx_out[gi])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= NW'(1);
            j_reg     <= '0;
            pass_reg  <= '0;
            iter_reg  <= '0;
            m_reg     <= '0;
            eig_reg   <= '0;
            stat_reg  <= ST_CONVERGED;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            j_reg     <= j_next;
            pass_reg  <= pass_next;
            iter_reg  <= iter_next;
            m_reg     <= m_next;
            eig_reg   <= eig_next;
            stat_reg  <= stat_next;
            ov_reg    <= out_load || (ov_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg  <= kind_next;
            idx_reg   <= idx_next;
            val_reg   <= val_next;
            last_reg  <= last_next;
            ostat_reg <= stat_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        pass_next  = pass_reg;
        iter_next  = iter_reg;
        m_next     = m_reg;
        eig_next   = eig_reg;
        stat_next  = stat_reg;
        ctl        = '0;
        out_load   = 1'b0;
        kind_next  = KIND_EIG;
        idx_next   = 3'd0;
        val_next   = eig_reg;
        last_next  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (mode)
                        MODE_MAT:
                        begin
                            ctl.wr_m = (int'(row) < MAX_ORDER) && (int'(col) < MAX_ORDER);
                        end
                        MODE_VEC:
                        begin
                            ctl.wr_v = (int'(row) < MAX_ORDER);
                        end
                        MODE_START:
                        begin
                            n_next     = n_calc;
                            iter_next  = '0;
                            state_next = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR:
            begin
                ctl.clr    = 1'b1;
                j_next     = '0;
                state_next = S_PH0;
            end
            S_PH0:
            begin
                state_next = S_PH1;
            end
            S_PH1:
            begin
                ctl.mul    = 1'b1;
                state_next = S_PH2;
            end
            S_PH2:
            begin
                ctl.acc = 1'b1;
                ctl.rot = 1'b1;
                j_next  = j_reg + NW'(1);
                if (j_reg + NW'(1) == n_reg)
                begin
                    state_next = S_SAT;
                end
                else
                begin
                    state_next = S_PH0;
                end
            end
            S_SAT:
            begin
                ctl.sat    = 1'b1;
                pass_next  = '0;
                state_next = S_MAXP;
            end
            S_MAXP:
            begin
                ctl.maxp  = 1'b1;
                pass_next = pass_reg + PASS_W'(1);
                if (pass_reg == PASS_W'(MAX_ORDER - 1))
                begin
                    state_next = S_CHKZ;
                end
            end
            S_CHKZ:
            begin
                m_next    = chain_max[WORD_BITS-1:0];
                iter_next = iter_reg + 16'd1;
                if (chain_max == '0)
                begin
                    eig_next   = '0;
                    stat_next  = ST_ZERO;
                    state_next = S_EMIT_EIG;
                end
                else
                begin
                    eig_next   = chain_max[WORD_BITS-1] ? {1'b0, {(WORD_BITS-1){1'b1}}}
                                                        : chain_max[WORD_BITS-1:0];
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                ctl.div_start = 1'b1;
                pass_next     = '0;
                state_next    = S_DIVR;
            end
            S_DIVR:
            begin
                ctl.div_step = 1'b1;
                pass_next    = pass_reg + PASS_W'(1);
                if (pass_reg == PASS_W'(DIV_STEPS - 1))
                begin
                    pass_next  = '0;
                    state_next = S_DMAX;
                end
            end
            S_DMAX:
            begin
                ctl.maxp  = 1'b1;
                ctl.sel_d = 1'b1;
                pass_next = pass_reg + PASS_W'(1);
                if (pass_reg == PASS_W'(MAX_ORDER - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                ctl.commit = 1'b1;
                if (chain_max < MAX_W'(tol_reg))
                begin
                    stat_next  = ST_CONVERGED;
                    state_next = S_EMIT_EIG;
                end
                else if (iter_reg >= maxi_reg)
                begin
                    stat_next  = ST_LIMIT;
                    state_next = S_EMIT_EIG;
                end
                else
                begin
                    state_next = S_CLR;
                end
            end
            S_EMIT_EIG:
            begin
                if (!ov_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    j_next     = '0;
                    state_next = S_EMIT_VEC;
                end
            end
            S_EMIT_VEC:
            begin
                kind_next = KIND_VEC;
                idx_next  = 3'(j_reg);
                val_next  = x_out[0];
                last_next = (j_reg + NW'(1) == n_reg);
                if (!ov_reg || !out_stall)
                begin
                    out_load = 1'b1;
                    ctl.rot  = 1'b1;
                    j_next   = j_reg + NW'(1);
                    if (j_reg + NW'(1) == n_reg)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid    = ov_reg;
    assign kind         = kind_reg;
    assign index        = idx_reg;
    assign result_value = val_reg;
    assign status       = ostat_reg;
    assign last         = last_reg;

    `PIE_ASSERT_NEXT(a_start_runs, in_acc && mode == MODE_START, state_reg == S_CLR)
    `PIE_ASSERT_NEXT(a_zero_stops, state_reg == S_CHKZ && chain_max == '0,
        state_reg == S_EMIT_EIG && stat_reg == ST_ZERO)
    `PIE_ASSERT_NEXT(a_last_ends, out_load && last_next, state_reg == S_IDLE)
    `PIE_ASSERT_NOW(a_eig_not_last, ov_reg && kind_reg == KIND_EIG, !last_reg)

endmodule
